@@ design/ast_pkg.sv @@
`timescale 1ns / 1ps

package ast_pkg;

  localparam int VALUE_W = 32;
  localparam int STEP_W  = 32;
  localparam int KEY_W   = 16;
  localparam int RUN_W   = 4;
  localparam int REV_W   = 16;
  localparam int ENTRY_W = KEY_W + STEP_W;
  localparam int IN_W    = 104;
  localparam int OUT_W   = 88;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    KIND_ANSWER   = 2'd0,
    KIND_RESTART  = 2'd1,
    KIND_TABLE_WR = 2'd2
  } kind_t;

  localparam logic [1:0] DIR_INIT = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;  // after a correct run
  localparam logic [1:0] DIR_UP   = 2'd2;  // after a wrong run

  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_LEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGER_EASY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_COUNT  = 3'd6;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;
  localparam logic [REV_W-1:0] REV_MAX = '1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t                   op;
    logic signed [VALUE_W:0]   a;
    logic        [STEP_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic                      ge0;
    logic        [VALUE_W-1:0] value;
  } alu_rsp_t;

endpackage

@@ design/ast_step_mem.sv @@
`timescale 1ns / 1ps

module ast_step_mem #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic                       wr_sel,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [ast_pkg::ENTRY_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic                       rd_sel,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [ast_pkg::ENTRY_W-1:0] rd_data
);

  // index 0: up table, index 1: down table
  logic [ast_pkg::ENTRY_W-1:0] mem [2][DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_sel][wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_sel][rd_addr];
    end
  end

endmodule

@@ design/ast_alu.sv @@
`timescale 1ns / 1ps

module ast_alu (
  input  ast_pkg::alu_req_t req,
  output ast_pkg::alu_rsp_t rsp
);

  localparam int SUM_W = ast_pkg::VALUE_W + 2;

  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] b_ext;
  logic signed [SUM_W-1:0] sum;
  logic                    in_range;

  assign a_ext = SUM_W'(req.a);
  assign b_ext = {2'b00, req.b};
  assign sum   = (req.op == ast_pkg::ALU_ADD) ? a_ext + b_ext : a_ext - b_ext;

  // in range when the bits above the value's sign all agree with it
  assign in_range = (sum[SUM_W-1:ast_pkg::VALUE_W-1] == '0) ||
                    (sum[SUM_W-1:ast_pkg::VALUE_W-1] == '1);

  always_comb begin
    rsp.ge0 = ~sum[SUM_W-1];
    if (in_range) begin
      rsp.value = sum[ast_pkg::VALUE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      rsp.value = {1'b1, {(ast_pkg::VALUE_W-1){1'b0}}};
    end else begin
      rsp.value = {1'b0, {(ast_pkg::VALUE_W-1){1'b1}}};
    end
  end

endmodule

@@ design/adaptive_staircase_tracker.sv @@
`timescale 1ns / 1ps
// Transformed up/down staircase tracker.
// Requests enter on s_tvalid/s_tready: s_tuser gives the kind (answer, restart,
// step table write) and the table select, s_tdata carries the fields. Every
// request yields exactly one result on m_tvalid/m_tready with the tracked value,
// step size, reversal flag, reversal count and direction.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it
// only while idle, the block itself does not enforce it. A table write or an
// unused kind goes through the finish state to the output register. An answer
// or a restart walks the selected step table entry by entry (memory read, then
// compare in the shared adder), at most TABLE_DEPTH entries; an answer with
// keep_step set skips the walk. s_tready is high only while the sequencer is idle.
// The output register parts the two sides: a new request is taken while a
// result waits; the sequencer holds its finished result until the register
// frees up, so a stalled receiver stalls the block after one request.
// Reset clears configuration to its defaults, the run state, the step and the
// output valid; step tables are undefined until written.
module adaptive_staircase_tracker #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // correct, trial_number, used_value, keep_step, entry_index, entry_key, entry_step
  input  logic [ast_pkg::IN_W-1:0]        s_tdata,
  // kind, table_select
  input  logic [2:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // current_value, step_size, was_reversal, reversal_count, direction
  output logic [ast_pkg::OUT_W-1:0]       m_tdata,
  input  logic                            cfg_we,
  input  logic [ast_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW_EXT = (IDX_W > 3) ? IDX_W : 3;
  localparam int LIM_W  = ($clog2(TABLE_DEPTH + 1) > 4) ? $clog2(TABLE_DEPTH + 1) : 4;
  localparam logic [IW_EXT:0]  DEPTH_IDX = (IW_EXT + 1)'(TABLE_DEPTH);
  localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_MOVE,
    ST_FIN
  } state_t;

  // request fields
  logic                              in_correct;
  logic [15:0]                       in_trial;
  logic [ast_pkg::VALUE_W-1:0]       in_used;
  logic                              in_keep;
  logic [2:0]                        in_entry_index;
  logic [ast_pkg::KEY_W-1:0]         in_entry_key;
  logic [ast_pkg::STEP_W-1:0]        in_entry_step;
  ast_pkg::kind_t                    in_kind;
  logic                              in_table_sel;

  assign in_correct     = s_tdata[0];
  assign in_trial       = s_tdata[16:1];
  assign in_used        = s_tdata[48:17];
  assign in_keep        = s_tdata[49];
  assign in_entry_index = s_tdata[52:50];
  assign in_entry_key   = s_tdata[68:53];
  assign in_entry_step  = s_tdata[100:69];
  assign in_kind        = ast_pkg::kind_t'(s_tuser[1:0]);
  assign in_table_sel   = s_tuser[2];

  // configuration
  logic [ast_pkg::RUN_W-1:0]   down_run_length;
  logic [ast_pkg::RUN_W-1:0]   up_run_length;
  logic                        larger_is_easier;
  logic [ast_pkg::VALUE_W-1:0] start_value;
  logic                        step_change_mode;
  logic [3:0]                  up_table_count;
  logic [3:0]                  down_table_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_run_length  <= 4'd2;
      up_run_length    <= 4'd1;
      larger_is_easier <= 1'b0;
      start_value      <= '0;
      step_change_mode <= 1'b0;
      up_table_count   <= '0;
      down_table_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ast_pkg::CFG_DOWN_LEN:    down_run_length  <= cfg_data[3:0];
        ast_pkg::CFG_UP_LEN:      up_run_length    <= cfg_data[3:0];
        ast_pkg::CFG_LARGER_EASY: larger_is_easier <= cfg_data[0];
        ast_pkg::CFG_START_VALUE: start_value      <= cfg_data;
        ast_pkg::CFG_STEP_MODE:   step_change_mode <= cfg_data[0];
        ast_pkg::CFG_UP_COUNT:    up_table_count   <= cfg_data[3:0];
        ast_pkg::CFG_DOWN_COUNT:  down_table_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // tracker state
  state_t                      state;
  logic [ast_pkg::RUN_W-1:0]   correct_run;
  logic [ast_pkg::RUN_W-1:0]   wrong_run;
  logic [1:0]                  track_direction;
  logic [ast_pkg::REV_W-1:0]   reversals;
  logic [ast_pkg::VALUE_W-1:0] tracked_value;
  logic [ast_pkg::STEP_W-1:0]  current_step;
  logic                        was_reversal;
  logic                        move_pend;
  logic                        increase;
  logic [ast_pkg::KEY_W-1:0]   threshold;
  logic                        walk_sel;
  logic [LIM_W-1:0]            walk_idx;
  logic [LIM_W-1:0]            walk_lim;

  // answer update, worked out on the accepted request
  logic [ast_pkg::RUN_W-1:0]   ans_correct_run;
  logic [ast_pkg::RUN_W-1:0]   ans_wrong_run;
  logic [1:0]                  ans_dir;
  logic                        ans_rev;
  logic                        ans_move;
  logic                        ans_inc;
  logic [ast_pkg::REV_W-1:0]   ans_reversals;

  always_comb begin
    ans_correct_run = '0;
    ans_wrong_run   = '0;
    if (in_correct) begin
      ans_correct_run = (correct_run == ast_pkg::RUN_MAX) ? correct_run
                                                          : correct_run + 1'b1;
    end else begin
      ans_wrong_run = (wrong_run == ast_pkg::RUN_MAX) ? wrong_run : wrong_run + 1'b1;
    end
    ans_dir  = track_direction;
    ans_rev  = 1'b0;
    ans_move = 1'b1;
    ans_inc  = 1'b0;
    priority if (ans_correct_run == down_run_length) begin
      ans_inc         = ~larger_is_easier;
      ans_correct_run = '0;
      ans_rev         = (track_direction == ast_pkg::DIR_UP);
      ans_dir         = ast_pkg::DIR_DOWN;
    end else if (ans_wrong_run == up_run_length) begin
      ans_inc       = larger_is_easier;
      ans_wrong_run = '0;
      ans_rev       = (track_direction == ast_pkg::DIR_DOWN);
      ans_dir       = ast_pkg::DIR_UP;
    end else begin
      ans_move = 1'b0;
    end
    ans_reversals = (ans_rev && reversals != ast_pkg::REV_MAX) ? reversals + 1'b1
                                                               : reversals;
  end

  function automatic logic [LIM_W-1:0] cap_count(input logic [3:0] cnt);
    logic [LIM_W-1:0] c;
    c = LIM_W'(cnt);
    return (c > DEPTH_LIM) ? DEPTH_LIM : c;
  endfunction

  // step table memory
  logic [IW_EXT-1:0]            wr_idx_ext;
  logic                         mem_wr_en;
  logic                         mem_rd_en;
  logic [ast_pkg::ENTRY_W-1:0]  mem_rd_data;
  logic [ast_pkg::KEY_W-1:0]    rd_key;
  logic [ast_pkg::STEP_W-1:0]   rd_step;
  logic                         accept;

  assign accept     = s_tvalid && s_tready;
  assign wr_idx_ext = IW_EXT'(in_entry_index);
  assign mem_wr_en  = accept && (in_kind == ast_pkg::KIND_TABLE_WR) &&
                      ({1'b0, wr_idx_ext} < DEPTH_IDX);
  assign mem_rd_en  = (state == ST_RD) && (walk_idx != walk_lim);
  assign rd_key     = mem_rd_data[ast_pkg::ENTRY_W-1:ast_pkg::STEP_W];
  assign rd_step    = mem_rd_data[ast_pkg::STEP_W-1:0];

  ast_step_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_sel  (in_table_sel),
    .wr_addr (wr_idx_ext[IDX_W-1:0]),
    .wr_data ({in_entry_key, in_entry_step}),
    .rd_en   (mem_rd_en),
    .rd_sel  (walk_sel),
    .rd_addr (walk_idx[IDX_W-1:0]),
    .rd_data (mem_rd_data)
  );

  // shared adder: key compare during the walk, saturating step at the end
  ast_pkg::alu_req_t alu_req;
  ast_pkg::alu_rsp_t alu_rsp;

  always_comb begin
    if (state == ST_MOVE) begin
      alu_req.op = increase ? ast_pkg::ALU_ADD : ast_pkg::ALU_SUB;
      alu_req.a  = {tracked_value[ast_pkg::VALUE_W-1], tracked_value};
      alu_req.b  = current_step;
    end else begin
      alu_req.op = ast_pkg::ALU_SUB;
      alu_req.a  = (ast_pkg::VALUE_W + 1)'(threshold);
      alu_req.b  = ast_pkg::STEP_W'(rd_key);
    end
  end

  ast_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      correct_run     <= '0;
      wrong_run       <= '0;
      track_direction <= ast_pkg::DIR_INIT;
      reversals       <= '0;
      tracked_value   <= '0;
      current_step    <= '0;
      was_reversal    <= 1'b0;
      move_pend       <= 1'b0;
      walk_idx        <= '0;
      walk_lim        <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            was_reversal <= 1'b0;
            move_pend    <= 1'b0;
            walk_idx     <= '0;
            unique case (in_kind)
              ast_pkg::KIND_ANSWER: begin
                tracked_value   <= in_used;
                correct_run     <= ans_correct_run;
                wrong_run       <= ans_wrong_run;
                track_direction <= ans_dir;
                reversals       <= ans_reversals;
                was_reversal    <= ans_rev;
                move_pend       <= ans_move;
                increase        <= ans_inc;
                threshold       <= step_change_mode ? in_trial : ans_reversals;
                walk_sel        <= (ans_dir == ast_pkg::DIR_DOWN);
                walk_lim        <= cap_count((ans_dir == ast_pkg::DIR_DOWN) ?
                                             down_table_count : up_table_count);
                state           <= in_keep ? ST_MOVE : ST_RD;
              end
              ast_pkg::KIND_RESTART: begin
                tracked_value   <= start_value;
                correct_run     <= '0;
                wrong_run       <= '0;
                track_direction <= ast_pkg::DIR_INIT;
                reversals       <= '0;
                threshold       <= '0;
                walk_sel        <= 1'b0;
                walk_lim        <= cap_count(up_table_count);
                state           <= ST_RD;
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_RD: begin
          state <= (walk_idx == walk_lim) ? ST_MOVE : ST_CMP;
        end
        ST_CMP: begin
          // stop at the first key above the threshold
          if (alu_rsp.ge0) begin
            current_step <= rd_step;
            walk_idx     <= walk_idx + 1'b1;
            state        <= ST_RD;
          end else begin
            state <= ST_MOVE;
          end
        end
        ST_MOVE: begin
          if (move_pend) begin
            tracked_value <= alu_rsp.value;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, track_direction, reversals, was_reversal,
                         current_step, tracked_value};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sequencer took a request while busy");

  a_walk_in_bounds: assert property (@(posedge clk) disable iff (rst)
    walk_idx <= walk_lim && walk_lim <= DEPTH_LIM)
    else $error("table walk ran past its limit");

  a_reversal_has_direction: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |-> m_tdata[82:81] != ast_pkg::DIR_INIT)
    else $error("reversal reported with initial direction");

  a_fin_loads_output: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && !m_tvalid |=> m_tvalid && state == ST_IDLE)
    else $error("finished result not loaded into free output register");
`endif

endmodule
